FILE: sv/csc_pkg.sv
// Shared types and constants for the climate sensor conditioner.
// Field widths, calibration limits, register indexes and the offset struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

	// item field widths
	localparam int TEMP_W = 12;
	localparam int HUM_W  = 10;
	localparam int LRAW_W = 13;
	localparam int LAVG_W = 12;
	localparam int ERR_W  = 16;

	// offset register widths
	localparam int TOFF_W = 8;
	localparam int HOFF_W = 10;
	localparam int LOFF_W = 13;

	// config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_OFFSET   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_OFFSET = 2'd2;

	// width of the light sum (raw + offset); holds any ADC_WIDTH up to 16
	localparam int LSUM_W = 17;

	// parameter defaults
	localparam int FILTER_DEPTH_DEF = 8;
	localparam int ADC_WIDTH_DEF    = 12;

	// offset clamp limits
	localparam logic signed [TOFF_W-1:0] TOFF_LO = -8'sd100;
	localparam logic signed [TOFF_W-1:0] TOFF_HI = 8'sd100;
	localparam logic signed [HOFF_W-1:0] HOFF_LO = -10'sd500;
	localparam logic signed [HOFF_W-1:0] HOFF_HI = 10'sd500;

	// calibrated range limits (tenths)
	localparam logic signed [TEMP_W:0] TEMP_LO = -13'sd500;
	localparam logic signed [TEMP_W:0] TEMP_HI = 13'sd1500;
	localparam logic signed [HUM_W+1:0] HUM_LO = 12'sd0;
	localparam logic signed [HUM_W+1:0] HUM_HI = 12'sd1000;

	typedef struct packed {
		logic signed [TOFF_W-1:0] temp_off;
		logic signed [HOFF_W-1:0] hum_off;
		logic signed [LOFF_W-1:0] light_off;
	} cal_cfg_t;

endpackage

`default_nettype wire

FILE: sv/climate_sensor_conditioner.sv
// Top level of the climate sensor conditioner.
// Depends on csc_pkg, csc_cfg and csc_ring.
//
// Takes one sample set per cycle unless the full output register is stalled. The
// item passes the input register, the stage-2 register and the output register,
// which holds its result until the receiver takes it.
// The pipeline moves as a whole whenever the output register is empty or being
// taken, so throughput is one item per cycle. Temperature and humidity get
// their offsets and are range checked; light is checked against 1.1x full
// scale, offset, clamped and, on a good in-range read, pushed into a FILTER_DEPTH-entry
// ring whose running total is updated in the same cycle. The mean is total/FILTER_DEPTH
// formed by a constant reciprocal multiply in the second stage. The ring has per-entry
// valid bits, so the block is usable directly after reset with no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module climate_sensor_conditioner #(
	parameter int FILTER_DEPTH = csc_pkg::FILTER_DEPTH_DEF,
	parameter int ADC_WIDTH    = csc_pkg::ADC_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [39:0]                    s_axis_tdata,  // temp_raw, hum_raw, light_raw
	input  wire logic [0:0]                     s_axis_tuser,  // sensor_ok
	// result stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [55:0]                         m_axis_tdata,  // temp_out, hum_out, light_avg,
	                                                           // error_tally
	output logic [3:0]                          m_axis_tuser,  // temp_valid, hum_valid,
	                                                           // light_valid, all_valid
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [csc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [csc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import csc_pkg::*;

	localparam int TOT_W  = ADC_WIDTH + $clog2(FILTER_DEPTH);
	localparam int RSH    = TOT_W + $clog2(FILTER_DEPTH);
	localparam int RECIP_W = RSH + 1;
	localparam int PROD_W = TOT_W + RECIP_W;
	localparam longint unsigned RECIP =
		((64'd1 << RSH) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH);
	localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP);
	localparam logic signed [LSUM_W-1:0] ADC_MAX_S = LSUM_W'((1 << ADC_WIDTH) - 1);
	localparam logic [31:0] LIGHT_LIM = 32'((11 * ((1 << ADC_WIDTH) - 1)) / 10);
	localparam int RAW_LO = 0;
	localparam int HUM_LSB = RAW_LO + TEMP_W;
	localparam int LGT_LSB = HUM_LSB + HUM_W;
	localparam int O_HUM_LSB = TEMP_W;
	localparam int O_LAVG_LSB = O_HUM_LSB + HUM_W;
	localparam int O_ERR_LSB = O_LAVG_LSB + LAVG_W;
	localparam int O_END = O_ERR_LSB + ERR_W;

	cal_cfg_t cfg;
	logic     en, proc;

	// stage 1: input register
	logic                    valid_s1, ok_s1;
	logic [TEMP_W-1:0]       temp_raw_s1;
	logic [HUM_W-1:0]        hum_raw_s1;
	logic [LRAW_W-1:0]       light_raw_s1;

	// stage 1 logic
	logic signed [TEMP_W:0]   t_sum;
	logic signed [HUM_W+1:0]  h_sum;
	logic signed [LSUM_W-1:0] l_sum;
	logic                     tv, hv, lv, av;
	logic [ADC_WIDTH-1:0]     l_clamp;
	logic [1:0]               n_err;
	logic [ERR_W:0]           err_inc;
	logic [ERR_W-1:0]         err_nxt, err_q;
	logic                     ring_wr;
	logic [TOT_W-1:0]         ring_total;

	// stage 2
	logic                valid_s2, tv_s2, hv_s2, lv_s2, av_s2;
	logic [TEMP_W-1:0]   temp_s2;
	logic [HUM_W-1:0]    hum_s2;
	logic [ERR_W-1:0]    err_s2;
	logic [PROD_W-1:0]   prod;
	logic [LAVG_W-1:0]   avg;

	// output register
	logic                out_valid_q, tv_q, hv_q, lv_q, av_q;
	logic [TEMP_W-1:0]   temp_q;
	logic [HUM_W-1:0]    hum_q;
	logic [LAVG_W-1:0]   lavg_q;
	logic [ERR_W-1:0]    err_out_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign proc          = valid_s1 && en;
	assign cfg_ready     = 1'b1;

	csc_cfg #(
		.ADC_WIDTH(ADC_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_axis_tvalid) begin
			ok_s1        <= s_axis_tuser[0];
			temp_raw_s1  <= s_axis_tdata[HUM_LSB-1:RAW_LO];
			hum_raw_s1   <= s_axis_tdata[LGT_LSB-1:HUM_LSB];
			light_raw_s1 <= s_axis_tdata[LGT_LSB+LRAW_W-1:LGT_LSB];
		end
	end

	// calibration, range checks and light clamp
	always_comb begin
		t_sum = $signed({temp_raw_s1[TEMP_W-1], temp_raw_s1}) + (TEMP_W+1)'(cfg.temp_off);
		h_sum = $signed({2'b00, hum_raw_s1}) + (HUM_W+2)'(cfg.hum_off);
		l_sum = $signed({{(LSUM_W-LRAW_W){1'b0}}, light_raw_s1}) + LSUM_W'(cfg.light_off);
		tv    = (t_sum >= TEMP_LO) && (t_sum <= TEMP_HI);
		hv    = (h_sum >= HUM_LO) && (h_sum <= HUM_HI);
		lv    = {{(32-LRAW_W){1'b0}}, light_raw_s1} <= LIGHT_LIM;
		av    = tv && hv && lv;
		if (l_sum < 0) begin
			l_clamp = '0;
		end else if (l_sum > ADC_MAX_S) begin
			l_clamp = ADC_WIDTH'(ADC_MAX_S);
		end else begin
			l_clamp = l_sum[ADC_WIDTH-1:0];
		end
	end

	// error tally: one per failed read or bad temperature or humidity, saturating
	always_comb begin
		if (!ok_s1) begin
			n_err = 2'd1;
		end else begin
			n_err = 2'({1'b0, !tv} + {1'b0, !hv});
		end
		err_inc = {1'b0, err_q} + (ERR_W+1)'(n_err);
		if (ok_s1 && av) begin
			err_nxt = '0;
		end else if (err_inc[ERR_W]) begin
			err_nxt = '1;
		end else begin
			err_nxt = err_inc[ERR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
		end else if (proc) begin
			err_q <= err_nxt;
		end
	end

	assign ring_wr = proc && ok_s1 && lv;

	csc_ring #(
		.DEPTH (FILTER_DEPTH),
		.DATA_W(ADC_WIDTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (ring_wr),
		.wr_data(l_clamp),
		.total  (ring_total)
	);

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			tv_s2   <= ok_s1 && tv;
			hv_s2   <= ok_s1 && hv;
			lv_s2   <= ok_s1 && lv;
			av_s2   <= ok_s1 && av;
			temp_s2 <= (ok_s1 && tv) ? t_sum[TEMP_W-1:0] : '0;
			hum_s2  <= (ok_s1 && hv) ? h_sum[HUM_W-1:0] : '0;
			err_s2  <= err_nxt;
		end
	end

	// mean = total / FILTER_DEPTH by reciprocal multiply
	assign prod = PROD_W'(ring_total) * RECIP_C;
	assign avg  = LAVG_W'(prod >> RSH);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			tv_q      <= tv_s2;
			hv_q      <= hv_s2;
			lv_q      <= lv_s2;
			av_q      <= av_s2;
			temp_q    <= temp_s2;
			hum_q     <= hum_s2;
			lavg_q    <= lv_s2 ? avg : '0;
			err_out_q <= err_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(56-O_END){1'b0}}, err_out_q, lavg_q, hum_q, temp_q};
	assign m_axis_tuser  = {av_q, lv_q, hv_q, tv_q};

endmodule

`default_nettype wire

FILE: sv/csc_cfg.sv
// Calibration offset registers with clamp-on-write.
// Depends on csc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csc_cfg #(
	parameter int ADC_WIDTH = csc_pkg::ADC_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [csc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [csc_pkg::CFG_DATA_W-1:0] wr_data,
	output csc_pkg::cal_cfg_t                   cfg
);
	import csc_pkg::*;

	localparam logic signed [LSUM_W-1:0] ADC_MAX_S = LSUM_W'((1 << ADC_WIDTH) - 1);

	cal_cfg_t cfg_q;
	logic signed [TOFF_W-1:0] t_in, t_clamp;
	logic signed [HOFF_W-1:0] h_in, h_clamp;
	logic signed [LSUM_W-1:0] l_in;
	logic signed [LOFF_W-1:0] l_clamp;

	// clamp each candidate value to its register limits
	always_comb begin
		t_in = $signed(wr_data[TOFF_W-1:0]);
		h_in = $signed(wr_data[HOFF_W-1:0]);
		l_in = LSUM_W'($signed(wr_data[LOFF_W-1:0]));
		if (t_in < TOFF_LO) begin
			t_clamp = TOFF_LO;
		end else if (t_in > TOFF_HI) begin
			t_clamp = TOFF_HI;
		end else begin
			t_clamp = t_in;
		end
		if (h_in < HOFF_LO) begin
			h_clamp = HOFF_LO;
		end else if (h_in > HOFF_HI) begin
			h_clamp = HOFF_HI;
		end else begin
			h_clamp = h_in;
		end
		if (l_in < -ADC_MAX_S) begin
			l_clamp = LOFF_W'(-ADC_MAX_S);
		end else if (l_in > ADC_MAX_S) begin
			l_clamp = LOFF_W'(ADC_MAX_S);
		end else begin
			l_clamp = LOFF_W'(l_in);
		end
	end

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TEMP_OFFSET:  cfg_q.temp_off  <= t_clamp;
				REG_HUM_OFFSET:   cfg_q.hum_off   <= h_clamp;
				REG_LIGHT_OFFSET: cfg_q.light_off <= l_clamp;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/csc_ring.sv
// Light sample ring with running total.
// One write per sample at the ring pointer; the entry it replaces is prefetched
// through a registered read. Per-entry valid bits make unwritten entries read zero.
`timescale 1ns / 1ps
`default_nettype none

module csc_ring #(
	parameter int DEPTH  = csc_pkg::FILTER_DEPTH_DEF,
	parameter int DATA_W = csc_pkg::ADC_WIDTH_DEF,
	localparam int TOT_W = DATA_W + $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [TOT_W-1:0]  total
);
	import csc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [PTR_W-1:0]  ptr_q, nxt_ptr, rd_addr;
	logic [DATA_W-1:0] rd_q, byp_q, old_val;
	logic              rd_vld_q, byp_sel_q;
	logic [TOT_W-1:0]  total_q;

	// entry currently under the pointer
	assign old_val = byp_sel_q ? byp_q : (rd_vld_q ? rd_q : '0);
	assign nxt_ptr = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign rd_addr = wr_en ? nxt_ptr : ptr_q;

	// storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_q] <= wr_data;
		end
		rd_q  <= mem[rd_addr];
		byp_q <= wr_data;
	end

	// pointer, valid bits and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			ptr_q     <= '0;
			rd_vld_q  <= 1'b0;
			byp_sel_q <= 1'b0;
			total_q   <= '0;
		end else begin
			rd_vld_q  <= vld_q[rd_addr];
			byp_sel_q <= wr_en && (rd_addr == ptr_q);
			if (wr_en) begin
				vld_q[ptr_q] <= 1'b1;
				ptr_q        <= nxt_ptr;
				total_q      <= total_q - TOT_W'(old_val) + TOT_W'(wr_data);
			end
		end
	end

	assign total = total_q;

endmodule

`default_nettype wire

FILE: sim/climate_sensor_conditioner_test.sv
// Self-checking bench for the climate sensor conditioner.
// Drives sample sets and offset writes, predicts every result with a scoreboard class.
// Depends on csc_pkg and climate_sensor_conditioner.
`timescale 1ns / 1ps

module climate_sensor_conditioner_test;
	import csc_pkg::*;

	localparam int FILTER_DEPTH = FILTER_DEPTH_DEF;
	localparam int ADC_MAX      = (1 << ADC_WIDTH_DEF) - 1;
	localparam int CAL_T_MIN    = -500;
	localparam int CAL_T_MAX    = 1500;
	localparam int CAL_H_MIN    = 0;
	localparam int CAL_H_MAX    = 1000;
	localparam int TALLY_MAX    = 65535;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		bit                       ok;
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
		logic [LRAW_W-1:0]        light;
	} sample_t;

	typedef struct {
		logic signed [TEMP_W-1:0] temp_out;
		logic                     temp_valid;
		logic [HUM_W-1:0]         hum_out;
		logic                     hum_valid;
		logic [LAVG_W-1:0]        light_avg;
		logic                     light_valid;
		logic                     all_valid;
		logic [ERR_W-1:0]         error_tally;
	} reading_t;

	// predicts conditioned readings and checks them in order
	class reading_scoreboard;
		reading_t expected_readings[$];
		int temp_off, hum_off, light_off;
		int light_hist[FILTER_DEPTH];
		int hist_ptr, hist_sum, err_cnt;
		int mismatches;

		function new();
			temp_off = 0;
			hum_off = 0;
			light_off = 0;
			foreach (light_hist[i]) light_hist[i] = 0;
			hist_ptr = 0;
			hist_sum = 0;
			err_cnt = 0;
			mismatches = 0;
		endfunction

		function int clamp_int(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void bump_error();
			if (err_cnt < TALLY_MAX) err_cnt++;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TEMP_OFFSET: temp_off = clamp_int(int'($signed(data[TOFF_W-1:0])), -100, 100);
				REG_HUM_OFFSET: hum_off = clamp_int(int'($signed(data[HOFF_W-1:0])), -500, 500);
				REG_LIGHT_OFFSET: begin
					light_off = clamp_int(int'($signed(data[LOFF_W-1:0])), -ADC_MAX, ADC_MAX);
				end
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			reading_t r;
			int t_cal, h_cal, l_cal;
			bit tv, hv, lv;
			r = '{default: '0};
			if (!s.ok) begin
				// read failure: only the tally moves
				bump_error();
				r.error_tally = err_cnt[ERR_W-1:0];
				expected_readings.push_back(r);
				return;
			end
			t_cal = int'(s.temp) + temp_off;
			h_cal = int'(s.hum) + hum_off;
			// reject light above 1.1x full scale, ring untouched
			lv = int'(s.light) * 10 <= ADC_MAX * 11;
			if (lv) begin
				l_cal = clamp_int(int'(s.light) + light_off, 0, ADC_MAX);
				hist_sum = hist_sum - light_hist[hist_ptr] + l_cal;
				light_hist[hist_ptr] = l_cal;
				hist_ptr = (hist_ptr + 1) % FILTER_DEPTH;
				r.light_avg = LAVG_W'(hist_sum / FILTER_DEPTH);
			end
			tv = t_cal >= CAL_T_MIN && t_cal <= CAL_T_MAX;
			if (!tv) begin
				t_cal = 0;
				bump_error();
			end
			hv = h_cal >= CAL_H_MIN && h_cal <= CAL_H_MAX;
			if (!hv) begin
				h_cal = 0;
				bump_error();
			end
			if (tv && hv && lv) err_cnt = 0;
			r.temp_out = t_cal[TEMP_W-1:0];
			r.temp_valid = tv;
			r.hum_out = h_cal[HUM_W-1:0];
			r.hum_valid = hv;
			r.light_valid = lv;
			r.all_valid = tv && hv && lv;
			r.error_tally = err_cnt[ERR_W-1:0];
			expected_readings.push_back(r);
		endfunction

		function void cmp_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void check_reading(reading_t act);
			reading_t e;
			if (expected_readings.size() == 0) begin
				$error("result item with no expected reading");
				mismatches++;
				return;
			end
			e = expected_readings.pop_front();
			cmp_field("temp_out", e.temp_out, act.temp_out);
			cmp_field("temp_valid", e.temp_valid, act.temp_valid);
			cmp_field("hum_out", e.hum_out, act.hum_out);
			cmp_field("hum_valid", e.hum_valid, act.hum_valid);
			cmp_field("light_avg", e.light_avg, act.light_avg);
			cmp_field("light_valid", e.light_valid, act.light_valid);
			cmp_field("all_valid", e.all_valid, act.all_valid);
			cmp_field("error_tally", e.error_tally, act.error_tally);
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [39:0]           s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [55:0]           m_axis_tdata;
	logic [3:0]            m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	reading_scoreboard sb;
	bit quiet;
	int cycle_cnt;

	climate_sensor_conditioner u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// input monitor: predict every accepted sample set
	always @(posedge clk) begin
		sample_t s;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			s.ok = s_axis_tuser[0];
			s.temp = s_axis_tdata[11:0];
			s.hum = s_axis_tdata[21:12];
			s.light = s_axis_tdata[34:22];
			sb.note_sample(s);
		end
	end

	// output monitor
	always @(posedge clk) begin
		reading_t a;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			a.temp_out = m_axis_tdata[11:0];
			a.hum_out = m_axis_tdata[21:12];
			a.light_avg = m_axis_tdata[33:22];
			a.error_tally = m_axis_tdata[49:34];
			a.temp_valid = m_axis_tuser[0];
			a.hum_valid = m_axis_tuser[1];
			a.light_valid = m_axis_tuser[2];
			a.all_valid = m_axis_tuser[3];
			sb.check_reading(a);
		end
	end

	// mostly short gaps, a few long ones, none in quiet stretches
	function automatic int next_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				@(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				n = next_gap();
				repeat (n) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
				n = $urandom_range(1, 20);
				repeat (n) begin
					@(negedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	task automatic send_sample(sample_t s);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, s.light, s.hum, s.temp};
		s_axis_tuser <= s.ok;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic idle_in(int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_offsets(logic [CFG_DATA_W-1:0] t, logic [CFG_DATA_W-1:0] h,
			logic [CFG_DATA_W-1:0] l);
		write_cfg(REG_TEMP_OFFSET, t);
		write_cfg(REG_HUM_OFFSET, h);
		write_cfg(REG_LIGHT_OFFSET, l);
		write_cfg(REG_UNUSED, CFG_DATA_W'($urandom));
	endtask

	// stop sending and let the pipeline empty
	task automatic wait_drained();
		idle_in(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic sample_t mk(bit ok, int t, int h, int l);
		sample_t s;
		s.ok = ok;
		s.temp = t[TEMP_W-1:0];
		s.hum = h[HUM_W-1:0];
		s.light = l[LRAW_W-1:0];
		return s;
	endfunction

	// random sample, aimed mostly at the calibrated valid ranges
	function automatic sample_t rand_sample();
		int t, h, l;
		case ($urandom_range(0, 9))
			0, 1: t = $urandom;
			2: t = ($urandom_range(0, 1) ? CAL_T_MIN : CAL_T_MAX) - sb.temp_off
				+ $urandom_range(0, 2) - 1;
			default: t = $urandom_range(0, CAL_T_MAX - CAL_T_MIN) + CAL_T_MIN - sb.temp_off;
		endcase
		case ($urandom_range(0, 9))
			0, 1: h = $urandom;
			2: h = ($urandom_range(0, 1) ? CAL_H_MIN : CAL_H_MAX) - sb.hum_off
				+ $urandom_range(0, 2) - 1;
			default: h = $urandom_range(CAL_H_MIN, CAL_H_MAX) - sb.hum_off;
		endcase
		case ($urandom_range(0, 9))
			0, 1: l = $urandom;
			2: l = $urandom_range(0, 1) ? $urandom_range(4502, 4507) : $urandom_range(0, 2) * 2047;
			default: l = $urandom_range(0, ADC_MAX);
		endcase
		return mk($urandom_range(0, 14) != 0, t, h, l);
	endfunction

	// stimulus
	initial begin
		sample_t directed[$];
		int ph;
		sb = new();
		quiet = 1'b0;
		cycle_cnt = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		set_offsets(0, 0, 0);

		// directed: field extremes and range edges with zero offsets
		directed.push_back(mk(0, 0, 500, 100));
		directed.push_back(mk(1, 0, 500, 100));
		directed.push_back(mk(1, -2048, 500, 200));
		directed.push_back(mk(1, 2047, 500, 300));
		directed.push_back(mk(1, CAL_T_MIN, 500, 400));
		directed.push_back(mk(1, CAL_T_MIN - 1, 500, 500));
		directed.push_back(mk(1, CAL_T_MAX, 500, 600));
		directed.push_back(mk(1, CAL_T_MAX + 1, 500, 700));
		directed.push_back(mk(1, 250, CAL_H_MIN, 800));
		directed.push_back(mk(1, 250, CAL_H_MAX, 900));
		directed.push_back(mk(1, 250, CAL_H_MAX + 1, 1000));
		directed.push_back(mk(1, 250, 1023, 0));
		directed.push_back(mk(1, 250, 400, 0));
		directed.push_back(mk(1, 250, 400, ADC_MAX));
		directed.push_back(mk(1, 250, 400, 4504));
		directed.push_back(mk(1, 250, 400, 4505));
		directed.push_back(mk(1, 250, 400, 8191));
		directed.push_back(mk(1, 2047, 1023, 8191));
		directed.push_back(mk(0, -2048, 1023, 8191));
		repeat (6) directed.push_back(mk(1, 0, 0, ADC_MAX));
		foreach (directed[i]) begin
			send_sample(directed[i]);
			idle_in(next_gap());
		end

		// random phases, each with its own offsets
		for (ph = 1; ph <= 8; ph++) begin
			wait_drained();
			case (ph)
				1: set_offsets(100, 500, ADC_MAX);
				2: set_offsets(-100, -500, -ADC_MAX);
				3: set_offsets(13'h0080, 13'h01FF, 13'h1000);
				4: set_offsets(13'h1F7F, 13'h1E0C, 13'h0FFF);
				default: set_offsets($urandom, $urandom, $urandom);
			endcase
			for (int i = 0; i < 140; i++) begin
				if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
				// hold off until every expected reading is back
				if (ph == 3 && i == 70) begin
					idle_in(1);
					while (sb.pending() != 0) @(posedge clk);
				end
				send_sample(rand_sample());
				idle_in(next_gap());
			end
		end

		// pile up errors on the tally, then clear it
		wait_drained();
		quiet = 1'b1;
		set_offsets(100, 500, 0);
		repeat (40) send_sample(mk($urandom_range(0, 7) != 0, 2047, 1023, $urandom));
		send_sample(mk(1, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0));
		quiet = 1'b0;

		wait_drained();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
sv/csc_pkg.sv
sv/csc_cfg.sv
sv/csc_ring.sv
sv/climate_sensor_conditioner.sv
sim/climate_sensor_conditioner_test.sv
